### design/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants for the point-in-triangle test
// Holds the transaction payloads, the front-to-back queue entry and the
// fixed arithmetic widths that follow from the coordinate width.
// ----------------------------------------------------------------------------
package pit_pkg;

    // Coordinate and derived arithmetic widths
    localparam int COORD_BITS  = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;   // difference of two coordinates
    localparam int PROD_BITS   = 2 * DIFF_BITS;    // product of two differences
    localparam int NORM_BITS   = PROD_BITS + 1;    // difference of two products

    // Queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Axis codes
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Input transaction
    typedef struct packed {
        logic signed [COORD_BITS-1:0] v0_x;
        logic signed [COORD_BITS-1:0] v0_y;
        logic signed [COORD_BITS-1:0] v0_z;
        logic signed [COORD_BITS-1:0] v1_x;
        logic signed [COORD_BITS-1:0] v1_y;
        logic signed [COORD_BITS-1:0] v1_z;
        logic signed [COORD_BITS-1:0] v2_x;
        logic signed [COORD_BITS-1:0] v2_y;
        logic signed [COORD_BITS-1:0] v2_z;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic signed [COORD_BITS-1:0] query_z;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic  inside_res;
        logic  degenerate;
        axis_t dropped_axis;
    } out_item_t;

    // Projected triangle and point, classified by the front
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pa0;
        logic signed [COORD_BITS-1:0] pa1;
        logic signed [COORD_BITS-1:0] pa2;
        logic signed [COORD_BITS-1:0] pb0;
        logic signed [COORD_BITS-1:0] pb1;
        logic signed [COORD_BITS-1:0] pb2;
        logic signed [COORD_BITS-1:0] qa;
        logic signed [COORD_BITS-1:0] qb;
        axis_t                        drop;
        logic                         degen;
    } proj_t;

endpackage

### design/pit_front.sv
// ----------------------------------------------------------------------------
// pit_front: normal computation, axis classification and projection
// Four-stage pipeline that never stalls. Entry is gated by a credit count
// covering every transaction in this pipeline and in the queue behind it.
// ----------------------------------------------------------------------------
module pit_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pit_pkg::in_item_t s_item,
    input  logic              pop,
    output logic              push,
    output pit_pkg::proj_t    push_data
);

    localparam int CW  = pit_pkg::COORD_BITS;
    localparam int DW  = pit_pkg::DIFF_BITS;
    localparam int PW  = pit_pkg::PROD_BITS;
    localparam int NW  = pit_pkg::NORM_BITS;
    localparam int QCW = pit_pkg::QUEUE_CW;

    logic                    accept;
    logic [QCW-1:0]          credit_reg, credit_next;

    logic signed [CW-1:0]    vtx_in [3][3];
    logic signed [CW-1:0]    vtx3   [3][3];
    logic signed [CW-1:0]    qry3   [3];
    logic signed [DW-1:0]    e1_c [3];
    logic signed [DW-1:0]    e2_c [3];

    logic                    s1_valid_reg;
    pit_pkg::in_item_t       s1_item_reg;
    logic signed [DW-1:0]    e1_reg [3];
    logic signed [DW-1:0]    e2_reg [3];

    logic                    s2_valid_reg;
    pit_pkg::in_item_t       s2_item_reg;
    logic signed [PW-1:0]    prod_reg [6];

    logic                    s3_valid_reg;
    pit_pkg::in_item_t       s3_item_reg;
    logic signed [NW-1:0]    norm_reg [3];

    logic [NW-1:0]           mag [3];
    logic                    norm_zero;
    pit_pkg::axis_t          drop_c;
    pit_pkg::proj_t          proj_c;

    logic                    push_valid_reg;
    pit_pkg::proj_t          push_data_reg;

    // Reserve a queue slot per accepted transaction, release it on pop
    assign s_ready     = (credit_reg != QCW'(pit_pkg::QUEUE_DEPTH));
    assign accept      = s_valid && s_ready;
    assign credit_next = credit_reg + QCW'(accept) - QCW'(pop);

    // Unpack the incoming vertices
    always_comb begin
        vtx_in[0][0] = s_item.v0_x;
        vtx_in[0][1] = s_item.v0_y;
        vtx_in[0][2] = s_item.v0_z;
        vtx_in[1][0] = s_item.v1_x;
        vtx_in[1][1] = s_item.v1_y;
        vtx_in[1][2] = s_item.v1_z;
        vtx_in[2][0] = s_item.v2_x;
        vtx_in[2][1] = s_item.v2_y;
        vtx_in[2][2] = s_item.v2_z;
    end

    // Form both edge vectors from the first vertex
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            e1_c[a] = DW'(vtx_in[1][a]) - DW'(vtx_in[0][a]);
            e2_c[a] = DW'(vtx_in[2][a]) - DW'(vtx_in[0][a]);
        end
    end

    // Unpack the stage-3 vertices and query point
    always_comb begin
        vtx3[0][0] = s3_item_reg.v0_x;
        vtx3[0][1] = s3_item_reg.v0_y;
        vtx3[0][2] = s3_item_reg.v0_z;
        vtx3[1][0] = s3_item_reg.v1_x;
        vtx3[1][1] = s3_item_reg.v1_y;
        vtx3[1][2] = s3_item_reg.v1_z;
        vtx3[2][0] = s3_item_reg.v2_x;
        vtx3[2][1] = s3_item_reg.v2_y;
        vtx3[2][2] = s3_item_reg.v2_z;
        qry3[0]    = s3_item_reg.query_x;
        qry3[1]    = s3_item_reg.query_y;
        qry3[2]    = s3_item_reg.query_z;
    end

    // Take magnitudes of the normal; the most negative value reads right unsigned
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag[a] = norm_reg[a][NW-1] ? $unsigned(-norm_reg[a]) : $unsigned(norm_reg[a]);
        end
    end

    assign norm_zero = (norm_reg[0] == '0) && (norm_reg[1] == '0) && (norm_reg[2] == '0);

    // Pick the dominant axis; ties go to x, then y
    always_comb begin
        if (norm_zero) begin
            drop_c = pit_pkg::AXIS_X;
        end else if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
            drop_c = pit_pkg::AXIS_X;
        end else if (mag[1] >= mag[2]) begin
            drop_c = pit_pkg::AXIS_Y;
        end else begin
            drop_c = pit_pkg::AXIS_Z;
        end
    end

    // Project onto the two remaining axes
    always_comb begin
        proj_c.drop  = drop_c;
        proj_c.degen = norm_zero;
        if (drop_c == pit_pkg::AXIS_X) begin
            proj_c.pa0 = vtx3[0][1];
            proj_c.pa1 = vtx3[1][1];
            proj_c.pa2 = vtx3[2][1];
            proj_c.qa  = qry3[1];
        end else begin
            proj_c.pa0 = vtx3[0][0];
            proj_c.pa1 = vtx3[1][0];
            proj_c.pa2 = vtx3[2][0];
            proj_c.qa  = qry3[0];
        end
        if (drop_c == pit_pkg::AXIS_Z) begin
            proj_c.pb0 = vtx3[0][1];
            proj_c.pb1 = vtx3[1][1];
            proj_c.pb2 = vtx3[2][1];
            proj_c.qb  = qry3[1];
        end else begin
            proj_c.pb0 = vtx3[0][2];
            proj_c.pb1 = vtx3[1][2];
            proj_c.pb2 = vtx3[2][2];
            proj_c.qb  = qry3[2];
        end
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            push_valid_reg <= 1'b0;
        end else begin
            credit_reg     <= credit_next;
            s1_valid_reg   <= accept;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            push_valid_reg <= s3_valid_reg;
        end
    end

    // Advance payload: edges, products, normal, projection
    always_ff @(posedge aclk) begin
        s1_item_reg   <= s_item;
        s2_item_reg   <= s1_item_reg;
        s3_item_reg   <= s2_item_reg;
        for (int a = 0; a < 3; a++) begin
            e1_reg[a] <= e1_c[a];
            e2_reg[a] <= e2_c[a];
        end
        prod_reg[0]   <= PW'(e1_reg[1]) * PW'(e2_reg[2]);
        prod_reg[1]   <= PW'(e1_reg[2]) * PW'(e2_reg[1]);
        prod_reg[2]   <= PW'(e1_reg[2]) * PW'(e2_reg[0]);
        prod_reg[3]   <= PW'(e1_reg[0]) * PW'(e2_reg[2]);
        prod_reg[4]   <= PW'(e1_reg[0]) * PW'(e2_reg[1]);
        prod_reg[5]   <= PW'(e1_reg[1]) * PW'(e2_reg[0]);
        norm_reg[0]   <= NW'(prod_reg[0]) - NW'(prod_reg[1]);
        norm_reg[1]   <= NW'(prod_reg[2]) - NW'(prod_reg[3]);
        norm_reg[2]   <= NW'(prod_reg[4]) - NW'(prod_reg[5]);
        push_data_reg <= proj_c;
    end

    assign push      = push_valid_reg;
    assign push_data = push_data_reg;

endmodule

### design/pit_queue.sv
// ----------------------------------------------------------------------------
// pit_queue: short FIFO between the front and the back
// Holds classified transactions so that each side stalls on its own. The
// front never pushes into a full queue because of its credit count.
// ----------------------------------------------------------------------------
module pit_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pit_pkg::proj_t push_data,
    input  logic           pop,
    output logic           q_valid,
    output pit_pkg::proj_t q_data
);

    localparam int DEPTH = pit_pkg::QUEUE_DEPTH;
    localparam int AW    = pit_pkg::QUEUE_AW;
    localparam int QCW   = pit_pkg::QUEUE_CW;

    pit_pkg::proj_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg,  count_next;

    assign q_valid     = (count_reg != '0);
    assign q_data      = entry_reg[rd_ptr_reg];
    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + QCW'(push) - QCW'(pop);

    // Track pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/pit_back.sv
// ----------------------------------------------------------------------------
// pit_back: side test on every edge of the triangle and result register
// Pipeline of edge vectors, products and sign compare, one lane per edge.
// The whole pipeline holds while the result register waits on the receiver.
// ----------------------------------------------------------------------------
module pit_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  pit_pkg::proj_t     q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output pit_pkg::out_item_t m_item
);

    localparam int CW = pit_pkg::COORD_BITS;
    localparam int DW = pit_pkg::DIFF_BITS;
    localparam int PW = pit_pkg::PROD_BITS;
    localparam int NW = pit_pkg::NORM_BITS;

    logic                 advance;
    logic signed [CW-1:0] pa [3];
    logic signed [CW-1:0] pb [3];
    logic signed [DW-1:0] ex_c [3], ey_c [3], fx_c [3], fy_c [3], gx_c [3], gy_c [3];

    logic                 b1_valid_reg;
    pit_pkg::axis_t       b1_drop_reg;
    logic                 b1_degen_reg;
    logic signed [DW-1:0] ex_reg [3], ey_reg [3], fx_reg [3], fy_reg [3], gx_reg [3], gy_reg [3];

    logic                 b2_valid_reg;
    pit_pkg::axis_t       b2_drop_reg;
    logic                 b2_degen_reg;
    logic signed [PW-1:0] mf1_reg [3], mf2_reg [3], mg1_reg [3], mg2_reg [3];

    logic signed [NW-1:0] cf [3], cg [3];
    logic [2:0]           opp_c;

    logic                 b3_valid_reg;
    pit_pkg::axis_t       b3_drop_reg;
    logic                 b3_degen_reg;
    logic [2:0]           opp_reg;

    logic                 m_valid_reg;
    pit_pkg::out_item_t   m_item_reg;

    // Move the pipeline whenever the result register can take a transaction
    assign advance = !m_valid_reg || m_ready;
    assign pop     = advance && q_valid;

    always_comb begin
        pa[0] = q_data.pa0;
        pa[1] = q_data.pa1;
        pa[2] = q_data.pa2;
        pb[0] = q_data.pb0;
        pb[1] = q_data.pb1;
        pb[2] = q_data.pb2;
    end

    // Edge i runs to vertex j; vertex k is opposite
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            int j;
            int k;
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            ex_c[i] = DW'(pa[j]) - DW'(pa[i]);
            ey_c[i] = DW'(pb[j]) - DW'(pb[i]);
            fx_c[i] = DW'(pa[k]) - DW'(pa[i]);
            fy_c[i] = DW'(pb[k]) - DW'(pb[i]);
            gx_c[i] = DW'(q_data.qa) - DW'(pa[i]);
            gy_c[i] = DW'(q_data.qb) - DW'(pb[i]);
        end
    end

    // Compare cross-product signs; a zero never flags outside
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cf[i]    = NW'(mf1_reg[i]) - NW'(mf2_reg[i]);
            cg[i]    = NW'(mg1_reg[i]) - NW'(mg2_reg[i]);
            opp_c[i] = (cf[i][NW-1] && !cg[i][NW-1] && (cg[i] != '0))
                    || (cg[i][NW-1] && !cf[i][NW-1] && (cf[i] != '0));
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            b1_valid_reg <= pop;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            m_valid_reg  <= b3_valid_reg;
        end
    end

    // Advance payload; hold while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            b1_drop_reg  <= q_data.drop;
            b1_degen_reg <= q_data.degen;
            b2_drop_reg  <= b1_drop_reg;
            b2_degen_reg <= b1_degen_reg;
            b3_drop_reg  <= b2_drop_reg;
            b3_degen_reg <= b2_degen_reg;
            for (int i = 0; i < 3; i++) begin
                ex_reg[i]  <= ex_c[i];
                ey_reg[i]  <= ey_c[i];
                fx_reg[i]  <= fx_c[i];
                fy_reg[i]  <= fy_c[i];
                gx_reg[i]  <= gx_c[i];
                gy_reg[i]  <= gy_c[i];
                mf1_reg[i] <= PW'(ex_reg[i]) * PW'(fy_reg[i]);
                mf2_reg[i] <= PW'(ey_reg[i]) * PW'(fx_reg[i]);
                mg1_reg[i] <= PW'(ex_reg[i]) * PW'(gy_reg[i]);
                mg2_reg[i] <= PW'(ey_reg[i]) * PW'(gx_reg[i]);
            end
            opp_reg                 <= opp_c;
            m_item_reg.inside_res   <= !b3_degen_reg && (opp_reg == '0);
            m_item_reg.degenerate   <= b3_degen_reg;
            m_item_reg.dropped_axis <= b3_drop_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### design/point_in_triangle_test.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test: point-in-triangle test by dominant-axis projection
// Tests whether a query point projects inside a 3D triangle.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one triangle and query point per transaction;
//   m_valid/m_ready/m_item return one result per transaction, in order.
//   Throughput is one transaction per cycle while the receiver keeps m_ready
//   high; the front pipeline is four stages feeding an 8-entry queue, and
//   the back pipeline is four stages ending in the result register.
//   s_ready drops only when the queue plus the front pipeline hold 8
//   transactions, which happens when the receiver stalls: the back pipeline
//   then holds in place, the queue fills, and input stops without loss.
//   A degenerate triangle (zero normal) returns inside_res 0, degenerate 1
//   and dropped_axis x. A point on an edge counts as inside.
//   Synchronous active-low reset empties the pipelines and the queue;
//   s_ready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module point_in_triangle_test (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pit_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output pit_pkg::out_item_t m_item
);

    logic           push;
    logic           pop;
    logic           q_valid;
    pit_pkg::proj_t push_data;
    pit_pkg::proj_t q_data;

    // Classify and project
    pit_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .pop       (pop),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple front and back
    pit_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    // Run the edge tests
    pit_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### design/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker: port-level checks for the point-in-triangle test
// Watches reset behavior, result stability and degenerate results.
// ----------------------------------------------------------------------------
module pit_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input pit_pkg::out_item_t m_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    // Report degenerate triangles as outside with x dropped
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.degenerate |->
            !m_item.inside_res && (m_item.dropped_axis == pit_pkg::AXIS_X))
        else $error("degenerate result carries inside or an axis");

    // Drop results at reset
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Accept input right after reset
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind point_in_triangle_test pit_checker u_pit_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

### tb/point_in_triangle_test_checker.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test_checker: result checker for the point-in-triangle test
// Watches both channels, classifies every accepted triangle with an exact
// integer model and compares each returned result, field by field, in order.
// ----------------------------------------------------------------------------
module point_in_triangle_test_checker
    import pit_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        fail_count,
    output int        pending,
    output int        results_seen,
    output int        inside_seen,
    output int        degenerate_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    out_item_t expected_results[$];

    // Exact classification of one triangle and query point
    function automatic out_item_t classify_point(input in_item_t t);
        longint    vtx[3][3];
        longint    pt[3];
        longint    e1[3];
        longint    e2[3];
        longint    nrm[3];
        longint    amag[3];
        longint    pa[3];
        longint    pb[3];
        longint    qa;
        longint    qb;
        longint    ex;
        longint    ey;
        longint    c_tri;
        longint    c_pt;
        axis_t     drop;
        int        ia;
        int        ib;
        int        j;
        int        k;
        bit        in_tri;
        out_item_t r;

        vtx[0][0] = $signed(t.v0_x);
        vtx[0][1] = $signed(t.v0_y);
        vtx[0][2] = $signed(t.v0_z);
        vtx[1][0] = $signed(t.v1_x);
        vtx[1][1] = $signed(t.v1_y);
        vtx[1][2] = $signed(t.v1_z);
        vtx[2][0] = $signed(t.v2_x);
        vtx[2][1] = $signed(t.v2_y);
        vtx[2][2] = $signed(t.v2_z);
        pt[0]     = $signed(t.query_x);
        pt[1]     = $signed(t.query_y);
        pt[2]     = $signed(t.query_z);

        // Normal from both edges leaving the first vertex
        for (int a = 0; a < 3; a++) begin
            e1[a] = vtx[1][a] - vtx[0][a];
            e2[a] = vtx[2][a] - vtx[0][a];
        end
        nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];

        if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) begin
            r.inside_res   = 1'b0;
            r.degenerate   = 1'b1;
            r.dropped_axis = AXIS_X;
            return r;
        end

        // Drop the dominant axis; ties favor x, then y
        for (int a = 0; a < 3; a++) begin
            amag[a] = (nrm[a] < 0) ? -nrm[a] : nrm[a];
        end
        if (amag[0] >= amag[1] && amag[0] >= amag[2]) begin
            drop = AXIS_X;
        end else if (amag[1] >= amag[2]) begin
            drop = AXIS_Y;
        end else begin
            drop = AXIS_Z;
        end
        ia = (drop == AXIS_X) ? 1 : 0;
        ib = (drop == AXIS_Z) ? 1 : 2;

        for (int i = 0; i < 3; i++) begin
            pa[i] = vtx[i][ia];
            pb[i] = vtx[i][ib];
        end
        qa = pt[ia];
        qb = pt[ib];

        // Point is outside if it sits strictly across any edge from the third vertex
        in_tri = 1'b1;
        for (int i = 0; i < 3; i++) begin
            j     = (i + 1) % 3;
            k     = (i + 2) % 3;
            ex    = pa[j] - pa[i];
            ey    = pb[j] - pb[i];
            c_tri = ex * (pb[k] - pb[i]) - ey * (pa[k] - pa[i]);
            c_pt  = ex * (qb - pb[i]) - ey * (qa - pa[i]);
            if ((c_tri > 0 && c_pt < 0) || (c_tri < 0 && c_pt > 0)) begin
                in_tri = 1'b0;
            end
        end

        r.inside_res   = in_tri;
        r.degenerate   = 1'b0;
        r.dropped_axis = drop;
        return r;
    endfunction

    // Compare results against the oldest prediction, then record new transactions
    always @(posedge aclk) begin
        out_item_t want;

        if (!aresetn) begin
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_item.inside_res === 1'b1) begin
                    inside_seen++;
                end
                if (m_item.degenerate === 1'b1) begin
                    degenerate_seen++;
                end
                if (expected_results.size() == 0) begin
                    $error("result with no transaction pending: inside_res %0b degenerate %0b dropped_axis %0d",
                           m_item.inside_res, m_item.degenerate, m_item.dropped_axis);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.inside_res !== want.inside_res) begin
                        $error("inside_res mismatch: expected %0b, actual %0b",
                               want.inside_res, m_item.inside_res);
                        fail_count++;
                    end
                    if (m_item.degenerate !== want.degenerate) begin
                        $error("degenerate mismatch: expected %0b, actual %0b",
                               want.degenerate, m_item.degenerate);
                        fail_count++;
                    end
                    if (m_item.dropped_axis !== want.dropped_axis) begin
                        $error("dropped_axis mismatch: expected %0d, actual %0d",
                               want.dropped_axis, m_item.dropped_axis);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(classify_point(s_item));
            end
        end
        pending = expected_results.size();
    end

endmodule

### tb/point_in_triangle_test_tb.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test_tb: testbench top for the point-in-triangle test
// Drives directed corner triangles, then random triangles of several shapes
// (wide random, small, interior points, flat) under varying back-pressure.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module point_in_triangle_test_tb;

    import pit_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CASES = 22;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int fail_count;
    int pending;
    int results_seen;
    int inside_seen;
    int degenerate_seen;
    int stall_pct;
    int sent_count;

    // Corner triangles: v0 xyz, v1 xyz, v2 xyz, query xyz
    int corner_cases [NUM_CASES][12] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1},
        '{0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 2, 0},
        '{0, 0, 0, 10, 0, 0, 0, 10, 0, 20, 20, 5},
        '{0, 0, 0, 10, 0, 0, 0, 10, 0, 5, 0, 7},
        '{0, 0, 0, 10, 0, 0, 0, 10, 0, 10, 0, 0},
        '{0, 0, 0, 10, 0, 0, 0, 10, 0, 5, 5, -3},
        '{0, 0, 0, 10, 0, 0, 0, 10, 0, 6, 5, 0},
        '{0, 0, 0, 0, 10, 0, 10, 0, 0, 3, 3, 0},
        '{0, 0, 0, 0, 10, 0, 0, 0, 10, 9, 1, 1},
        '{0, 0, 0, 10, 0, 0, 0, 0, 10, 0, 1, 20},
        '{1, 0, 0, 0, 1, 0, 0, 0, 1, 5, 0, 0},
        '{0, 0, 0, 5, 0, 0, 0, 5, -5, 1, 9, -1},
        '{0, 0, 0, 0, 5, 0, 5, 0, -5, 2, 2, -2},
        '{0, 0, 0, 0, 0, 5, 5, -5, 0, 7, 1, 1},
        '{-32768, -32768, -32768, 32767, -32768, -32768,
          -32768, 32767, 32767, 32767, 32767, 32767},
        '{32767, 32767, 32767, -32768, 32767, -32768,
          32767, -32768, -32768, -32768, -32768, -32768},
        '{-32768, -32768, -32768, -32768, -32768, -32768,
          -32768, -32768, -32768, -32768, -32768, -32768},
        '{32767, 32767, 32767, 32767, 32767, 32767,
          32767, 32767, 32767, 32767, 32767, 32767},
        '{-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0, 0, 0, -32768},
        '{7, -3, 9, 7, -3, 9, 100, 200, -300, 7, -3, 9},
        '{0, 0, 0, 100, 0, 3, 0, 100, -7, 50, 49, 0}
    };

    point_in_triangle_test uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    point_in_triangle_test_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_seen    (results_seen),
        .inside_seen     (inside_seen),
        .degenerate_seen (degenerate_seen)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Symmetric random value in [-r, r]
    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // Pack twelve coordinates, keeping the low bits of each
    function automatic in_item_t pack_coords(input int c[12]);
        in_item_t it;

        for (int i = 0; i < 12; i++) begin
            it[(11 - i) * COORD_BITS +: COORD_BITS] = c[i][COORD_BITS-1:0];
        end
        return it;
    endfunction

    // Random triangle: wide random, small local, interior point or flat
    function automatic in_item_t make_triangle();
        int c[12];
        int base[3];
        int d[3];
        int kind;
        int r;
        int k;
        int w0;
        int w1;
        int w2;

        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0: r = 3;
            1: r = 60;
            default: r = 2000;
        endcase
        for (int a = 0; a < 3; a++) begin
            base[a] = (r == 3 && $urandom_range(0, 1)) ? 0 : spread(30000);
        end

        if (kind < 35) begin
            for (int i = 0; i < 12; i++) begin
                c[i] = $urandom;
            end
        end else if (kind < 85) begin
            for (int v = 0; v < 3; v++) begin
                for (int a = 0; a < 3; a++) begin
                    c[v * 3 + a] = base[a] + spread(r);
                end
            end
            if (kind < 60) begin
                for (int a = 0; a < 3; a++) begin
                    c[9 + a] = base[a] + spread(r + r / 2);
                end
            end else begin
                // Weighted mean of the vertices, truncated per coordinate, lands inside, on an edge or just outside
                w0 = $urandom_range(0, 4);
                w1 = $urandom_range(0, 4);
                w2 = $urandom_range(1, 4);
                for (int a = 0; a < 3; a++) begin
                    c[9 + a] = (w0 * c[a] + w1 * c[3 + a] + w2 * c[6 + a])
                               / (w0 + w1 + w2);
                end
            end
        end else begin
            // Collinear or repeated vertices
            k = spread(2);
            for (int a = 0; a < 3; a++) begin
                d[a]     = spread(r);
                c[a]     = base[a] + spread(r);
                c[3 + a] = c[a] + d[a];
                c[6 + a] = c[a] + k * d[a];
                c[9 + a] = base[a] + spread(r);
            end
        end
        return pack_coords(c);
    endfunction

    // Present one transaction and hold it until accepted; returns at a falling edge
    task automatic send_item(input in_item_t it);
        s_item  <= it;
        s_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sent_count++;
        @(negedge aclk);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_input(input int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // Hold the sender until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
    endtask

    // Random triangles with the given sender gap and receiver stall rates
    task automatic run_phase(input int count, input int gap_pct, input int stall_rate);
        stall_pct = stall_rate;
        for (int n = 0; n < count; n++) begin
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                idle_input($urandom_range(1, 19));
            end
            send_item(make_triangle());
        end
    endtask

    // Receiver: stall in random bursts at the rate the current phase sets
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Stimulus and verdict
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        stall_pct = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Corner triangles, with light back-pressure
        stall_pct = 5;
        for (int i = 0; i < NUM_CASES; i++) begin
            send_item(pack_coords(corner_cases[i]));
        end
        drain_results();

        run_phase(600, 10, 3);
        run_phase(200, 0, 0);
        drain_results();
        run_phase(600, 35, 10);
        drain_results();
        // Final stretch streams at full rate
        run_phase(430, 0, 0);

        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge aclk);

        $display("Sent %0d triangles: corner cases, wide random, small, interior and flat.",
                 sent_count);
        $display("Checked %0d results, %0d inside and %0d degenerate.",
                 results_seen, inside_seen, degenerate_seen);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
